// ===== hw/rtl/mbp_pkg.sv =====
// Shared types, character codes, parser phase codes and the command/status
// structs that join the controller and the datapath of the multipart parser.
// No dependencies.
package mbp_pkg;

   // Boundary storage
   localparam int MAX_BOUNDARY = 56;
   localparam int NUM_WORDS    = 7;
   localparam int WORD_W       = 64;

   // Payload of the request and result channels
   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_ends;
   } req_type;

   typedef struct packed {
      logic [3:0] event_kind;
      logic [7:0] event_byte;
      logic       last_event;
   } rsp_type;

   // Configuration register indexes
   localparam logic [2:0] CSR_BOUNDARY_LEN = 3'd0;

   // Characters
   localparam logic [7:0] CHAR_CR     = 8'd13;
   localparam logic [7:0] CHAR_LF     = 8'd10;
   localparam logic [7:0] CHAR_HYPHEN = 8'h2d;
   localparam logic [7:0] CHAR_COLON  = 8'h3a;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z  = 8'h7a;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5a;

   // Event kinds
   localparam logic [3:0] EV_PART_BEGIN = 4'd0;
   localparam logic [3:0] EV_NAME_BYTE  = 4'd1;
   localparam logic [3:0] EV_NAME_END   = 4'd2;
   localparam logic [3:0] EV_VALUE_BYTE = 4'd3;
   localparam logic [3:0] EV_VALUE_END  = 4'd4;
   localparam logic [3:0] EV_HDR_DONE   = 4'd5;
   localparam logic [3:0] EV_DATA_BYTE  = 4'd6;
   localparam logic [3:0] EV_PART_END   = 4'd7;
   localparam logic [3:0] EV_BODY_END   = 4'd8;
   localparam logic [3:0] EV_ERROR      = 4'd9;

   // Parser phases
   localparam logic [3:0] PH_START  = 4'd0;
   localparam logic [3:0] PH_NAME   = 4'd1;
   localparam logic [3:0] PH_VSTART = 4'd2;
   localparam logic [3:0] PH_VALUE  = 4'd3;
   localparam logic [3:0] PH_VLF    = 4'd4;
   localparam logic [3:0] PH_HLF    = 4'd5;
   localparam logic [3:0] PH_DATA   = 4'd6;
   localparam logic [3:0] PH_ALMOST = 4'd7;
   localparam logic [3:0] PH_BOUND  = 4'd8;
   localparam logic [3:0] PH_AEND   = 4'd9;
   localparam logic [3:0] PH_FHYPH  = 4'd10;
   localparam logic [3:0] PH_PLF    = 4'd11;
   localparam logic [3:0] PH_END    = 4'd12;
   localparam logic [3:0] PH_ERR    = 4'd13;

   // Event source selected for emission, in emission order
   localparam logic [1:0] SEL_HDR   = 2'd0;
   localparam logic [1:0] SEL_FLUSH = 2'd1;
   localparam logic [1:0] SEL_MAIN  = 2'd2;
   localparam logic [1:0] SEL_ERR   = 2'd3;

   typedef struct packed {
      logic       load;   // take the request and plan its events
      logic       emit;   // push one event into the result register
      logic [1:0] sel;    // which pending source to emit
      logic       last;   // this event closes the request
   } dp_cmd_type;

   typedef struct packed {
      logic hdr_pend;
      logic flush_pend;
      logic flush_one;
      logic main_pend;
      logic err_pend;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/mbp_ctrl.sv =====
// Controller of the multipart parser: takes one request at a time and
// drains its planned events in order. Depends on mbp_pkg.
module mbp_ctrl
   import mbp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_BUSY = 1'b1;

   logic state_ff;
   logic state_in;
   logic any_pend;

   assign any_pend = status.hdr_pend | status.flush_pend | status.main_pend | status.err_pend;
   assign req_stall = (state_ff != S_IDLE);

   // Take a request while idle; while busy, pick the next event source and tell whether it is the final one
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            if (!any_pend) begin
               state_in = S_IDLE;
            end else begin
               if (status.hdr_pend) begin
                  cmd.sel  = SEL_HDR;
                  cmd.last = !status.flush_pend && !status.main_pend && !status.err_pend;
               end else if (status.flush_pend) begin
                  cmd.sel  = SEL_FLUSH;
                  cmd.last = status.flush_one && !status.main_pend && !status.err_pend;
               end else if (status.main_pend) begin
                  cmd.sel  = SEL_MAIN;
                  cmd.last = !status.err_pend;
               end else begin
                  cmd.sel  = SEL_ERR;
                  cmd.last = 1'b1;
               end
               cmd.emit = status.out_free;
               if (status.out_free && cmd.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/mbp_datapath.sv =====
// Datapath of the multipart parser: boundary registers, parser state, the
// per-request event plan and the result register. Depends on mbp_pkg.
module mbp_datapath
   import mbp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_payload,
   input  logic          csr_write,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_wdata,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_payload
);

   // Configuration
   logic [5:0]                       blen_ff, blen_in;
   logic [NUM_WORDS-1:0][WORD_W-1:0] bwords_ff, bwords_in;

   // Parser state
   logic [3:0] phase_ff, phase_in;
   logic [5:0] mc_ff, mc_in;
   logic       hdp_ff, hdp_in;

   // Event plan of the current request
   logic       hdr_pend_ff, hdr_pend_in;
   logic [5:0] flush_idx_ff, flush_idx_in;
   logic [5:0] flush_left_ff, flush_left_in;
   logic       main_pend_ff, main_pend_in;
   logic [3:0] main_kind_ff, main_kind_in;
   logic [7:0] main_byte_ff, main_byte_in;
   logic       err_pend_ff, err_pend_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic [5:0] eff_len;
   logic [5:0] total;
   logic [5:0] look_k;
   logic [7:0] delim;
   logic [7:0] flush_char;
   logic [5:0] mc_inc;
   logic [5:0] flush_keep;
   logic [7:0] c;
   logic       is_name_char;

   // Character k of the delimiter: two hyphens, then the boundary
   function automatic logic [7:0] delim_char(input logic [5:0] k,
                                             input logic [NUM_WORDS-1:0][WORD_W-1:0] w);
      logic [5:0] j;
      logic [7:0] r;
      j = k - 6'd2;
      if (k < 6'd2) begin
         r = CHAR_HYPHEN;
      end else if (j >= 6'(MAX_BOUNDARY)) begin
         r = 8'd0;
      end else begin
         r = w[j[5:3]][{j[2:0], 3'b000} +: 8];
      end
      return r;
   endfunction

   // Clamp the boundary length
   always_comb begin
      if (blen_ff == 6'd0) begin
         eff_len = 6'd1;
      end else if (blen_ff > 6'(MAX_BOUNDARY)) begin
         eff_len = 6'(MAX_BOUNDARY);
      end else begin
         eff_len = blen_ff;
      end
   end
   assign total = eff_len + 6'd2;

   // One delimiter lookup: match position at load, flush position otherwise
   assign look_k     = cmd.load ? mc_ff : (flush_idx_ff - 6'd2);
   assign delim      = delim_char(look_k, bwords_ff);
   assign flush_char = (flush_idx_ff == 6'd0) ? CHAR_CR :
                       (flush_idx_ff == 6'd1) ? CHAR_LF : delim;

   assign c            = req_payload.in_byte;
   assign mc_inc       = mc_ff + 6'd1;
   assign flush_keep   = (mc_ff < total) ? mc_ff : total;
   assign is_name_char = (c == CHAR_HYPHEN) ||
                         (c inside {[CHAR_LOW_A:CHAR_LOW_Z], [CHAR_UP_A:CHAR_UP_Z]});

   // Configuration writes
   always_comb begin
      blen_in   = blen_ff;
      bwords_in = bwords_ff;
      if (csr_write) begin
         if (csr_index == CSR_BOUNDARY_LEN) begin
            blen_in = csr_wdata[5:0];
         end else begin
            bwords_in[csr_index - 3'd1] = csr_wdata;
         end
      end
   end

   // Plan the events of a request and advance the parser; drain on emit
   always_comb begin
      phase_in      = phase_ff;
      mc_in         = mc_ff;
      hdp_in        = hdp_ff;
      hdr_pend_in   = hdr_pend_ff;
      flush_idx_in  = flush_idx_ff;
      flush_left_in = flush_left_ff;
      main_pend_in  = main_pend_ff;
      main_kind_in  = main_kind_ff;
      main_byte_in  = main_byte_ff;
      err_pend_in   = err_pend_ff;

      if (cmd.emit) begin
         case (cmd.sel)
            SEL_HDR:   hdr_pend_in = 1'b0;
            SEL_FLUSH: begin
               flush_idx_in  = flush_idx_ff + 6'd1;
               flush_left_in = flush_left_ff - 6'd1;
            end
            SEL_MAIN:  main_pend_in = 1'b0;
            default:   err_pend_in = 1'b0;
         endcase
      end

      if (cmd.load) begin
         hdr_pend_in   = 1'b0;
         flush_idx_in  = 6'd0;
         flush_left_in = 6'd0;
         main_pend_in  = 1'b0;
         main_kind_in  = EV_DATA_BYTE;
         main_byte_in  = c;
         err_pend_in   = 1'b0;
         case (phase_ff)
            PH_START: begin
               if (mc_ff < total) begin
                  if (c == delim) begin
                     mc_in = mc_inc;
                  end else begin
                     err_pend_in = 1'b1;
                     phase_in    = PH_ERR;
                  end
               end else if (mc_ff == total) begin
                  if (c == CHAR_CR) begin
                     mc_in = mc_inc;
                  end else begin
                     err_pend_in = 1'b1;
                     phase_in    = PH_ERR;
                  end
               end else if (c == CHAR_LF) begin
                  main_pend_in = 1'b1;
                  main_kind_in = EV_PART_BEGIN;
                  main_byte_in = 8'd0;
                  mc_in        = 6'd0;
                  phase_in     = PH_NAME;
               end else begin
                  err_pend_in = 1'b1;
                  phase_in    = PH_ERR;
               end
            end
            PH_NAME: begin
               if (c == CHAR_CR) begin
                  phase_in = PH_HLF;
               end else if (c == CHAR_COLON) begin
                  main_pend_in = 1'b1;
                  main_kind_in = EV_NAME_END;
                  main_byte_in = 8'd0;
                  phase_in     = PH_VSTART;
               end else if (is_name_char) begin
                  main_pend_in = 1'b1;
                  main_kind_in = EV_NAME_BYTE;
               end else begin
                  err_pend_in = 1'b1;
                  phase_in    = PH_ERR;
               end
            end
            PH_VSTART, PH_VALUE: begin
               if (phase_ff == PH_VSTART && c == CHAR_SPACE) begin
                  phase_in = PH_VSTART;
               end else if (c == CHAR_CR) begin
                  main_pend_in = 1'b1;
                  main_kind_in = EV_VALUE_END;
                  main_byte_in = 8'd0;
                  phase_in     = PH_VLF;
               end else begin
                  main_pend_in = 1'b1;
                  main_kind_in = EV_VALUE_BYTE;
                  phase_in     = PH_VALUE;
               end
            end
            PH_VLF: begin
               if (c == CHAR_LF) begin
                  phase_in = PH_NAME;
               end else begin
                  err_pend_in = 1'b1;
                  phase_in    = PH_ERR;
               end
            end
            PH_HLF: begin
               if (c == CHAR_LF) begin
                  phase_in = PH_DATA;
                  hdp_in   = 1'b1;
               end else begin
                  err_pend_in = 1'b1;
                  phase_in    = PH_ERR;
               end
            end
            PH_DATA: begin
               if (hdp_ff) begin
                  hdr_pend_in = 1'b1;
                  hdp_in      = 1'b0;
               end
               if (c == CHAR_CR) begin
                  phase_in = PH_ALMOST;
               end else begin
                  main_pend_in = 1'b1;
               end
            end
            PH_ALMOST: begin
               if (c == CHAR_LF) begin
                  phase_in = PH_BOUND;
                  mc_in    = 6'd0;
               end else begin
                  // release the held CR; a further CR is held anew, any other byte is data
                  flush_left_in = 6'd1;
                  if (c == CHAR_CR) begin
                     phase_in = PH_ALMOST;
                  end else begin
                     phase_in     = PH_DATA;
                     main_pend_in = 1'b1;
                  end
               end
            end
            PH_BOUND: begin
               if (c != delim) begin
                  // release CR LF and the matched delimiter prefix
                  flush_left_in = flush_keep + 6'd2;
                  mc_in         = 6'd0;
                  if (c == CHAR_CR) begin
                     phase_in = PH_ALMOST;
                  end else begin
                     phase_in     = PH_DATA;
                     main_pend_in = 1'b1;
                  end
               end else if (mc_inc >= total) begin
                  main_pend_in = 1'b1;
                  main_kind_in = EV_PART_END;
                  main_byte_in = 8'd0;
                  mc_in        = 6'd0;
                  phase_in     = PH_AEND;
               end else begin
                  mc_in = mc_inc;
               end
            end
            PH_AEND: begin
               if (c == CHAR_HYPHEN) begin
                  phase_in = PH_FHYPH;
               end else if (c == CHAR_CR) begin
                  phase_in = PH_PLF;
               end else begin
                  err_pend_in = 1'b1;
                  phase_in    = PH_ERR;
               end
            end
            PH_FHYPH: begin
               if (c == CHAR_HYPHEN) begin
                  main_pend_in = 1'b1;
                  main_kind_in = EV_BODY_END;
                  main_byte_in = 8'd0;
                  phase_in     = PH_END;
               end else begin
                  err_pend_in = 1'b1;
                  phase_in    = PH_ERR;
               end
            end
            PH_PLF: begin
               if (c == CHAR_LF) begin
                  main_pend_in = 1'b1;
                  main_kind_in = EV_PART_BEGIN;
                  main_byte_in = 8'd0;
                  phase_in     = PH_NAME;
               end else begin
                  err_pend_in = 1'b1;
                  phase_in    = PH_ERR;
               end
            end
            PH_END, PH_ERR: begin
               phase_in = phase_ff;
            end
            default: begin
               err_pend_in = 1'b1;
               phase_in    = PH_ERR;
            end
         endcase
         // stream ended before the body end
         if (req_payload.stream_ends && phase_in != PH_END && phase_in != PH_ERR) begin
            err_pend_in = 1'b1;
            phase_in    = PH_ERR;
         end
      end
   end

   // Build the selected event; hold the result register while stalled
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.last_event = cmd.last;
         case (cmd.sel)
            SEL_HDR: begin
               rsp_in.event_kind = EV_HDR_DONE;
               rsp_in.event_byte = 8'd0;
            end
            SEL_FLUSH: begin
               rsp_in.event_kind = EV_DATA_BYTE;
               rsp_in.event_byte = flush_char;
            end
            SEL_MAIN: begin
               rsp_in.event_kind = main_kind_ff;
               rsp_in.event_byte = main_byte_ff;
            end
            default: begin
               rsp_in.event_kind = EV_ERROR;
               rsp_in.event_byte = 8'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blen_ff       <= 6'd1;
         bwords_ff     <= '0;
         phase_ff      <= PH_START;
         mc_ff         <= 6'd0;
         hdp_ff        <= 1'b0;
         hdr_pend_ff   <= 1'b0;
         flush_left_ff <= 6'd0;
         main_pend_ff  <= 1'b0;
         err_pend_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         blen_ff       <= blen_in;
         bwords_ff     <= bwords_in;
         phase_ff      <= phase_in;
         mc_ff         <= mc_in;
         hdp_ff        <= hdp_in;
         hdr_pend_ff   <= hdr_pend_in;
         flush_left_ff <= flush_left_in;
         main_pend_ff  <= main_pend_in;
         err_pend_ff   <= err_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flush_idx_ff <= flush_idx_in;
      main_kind_ff <= main_kind_in;
      main_byte_ff <= main_byte_in;
      rsp_ff       <= rsp_in;
   end

   assign status.hdr_pend   = hdr_pend_ff;
   assign status.flush_pend = (flush_left_ff != 6'd0);
   assign status.flush_one  = (flush_left_ff == 6'd1);
   assign status.main_pend  = main_pend_ff;
   assign status.err_pend   = err_pend_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hw/rtl/multipart_body_parser_unit.sv =====
// Multipart body parser: streams body bytes in and parse events out.
// Top level; instantiates mbp_ctrl and mbp_datapath, uses mbp_pkg.
// Usage:
//   Request channel (req_valid/req_stall/req_payload) carries one body byte
//   and a stream-end flag. Result channel (rsp_valid/rsp_stall/rsp_payload)
//   carries events; last_event marks the final event of a request.
//   The csr_ port writes the boundary length (index 0) and the seven
//   boundary words (indexes 1..7); write only while the block is idle.
// Timing:
//   A request is taken while the sequencer is idle; its events then follow
//   one per cycle from the result register while rsp_stall is low. An
//   ordinary data byte makes one event. A failed delimiter match releases
//   the held CR, LF and delimiter prefix as data, up to 59 extra events,
//   one per cycle while rsp_stall is low.
//   The event sequencer handles one request at a time; req_stall stays
//   high until its last event is loaded into the result register.
// Reset: synchronous; clears the parser to the opening-delimiter phase,
//   the boundary length to 1, the boundary words to zero, drops any event.
// Stall: while rsp_stall is high the result register holds its event and
//   the sequencer waits; nothing is lost or repeated.
module multipart_body_parser_unit
   import mbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequence requests and events
   mbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Parse and hold the result register
   mbp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
